// ===== design/psrp_pkg.sv =====
// Shared constants and codes for the PWM sample ring player.
`timescale 1ns / 1ps

package psrp_pkg;

  // Default geometry of the sample ring
  localparam int unsigned BuffersDefault          = 4;
  localparam int unsigned SamplesPerBufferDefault = 1024;
  localparam int unsigned DutyWidthDefault        = 16;
  localparam int unsigned StoreDepthDefault       = BuffersDefault * SamplesPerBufferDefault;

  // Period register
  localparam int unsigned PeriodW = 16;
  localparam logic [PeriodW-1:0] PeriodReset = 16'd33333;

  // Input beat kinds
  typedef enum logic {
    OpTick  = 1'b0,
    OpWrite = 1'b1
  } op_e;

endpackage

// ===== design/psrp_sample_mem.sv =====
// Sample store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module psrp_sample_mem #(
  parameter int unsigned Depth = psrp_pkg::StoreDepthDefault,
  parameter int unsigned Width = psrp_pkg::DutyWidthDefault,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/pwm_sample_ring_player.sv =====
// PWM sample ring player: counter, compare, playback pointer and result buffering.
`timescale 1ns / 1ps
// Throughput: one beat per cycle when the skid entry is empty; the single read
// port of the sample store is used only at period start and its read data
// serves as the shadow compare. A two-entry output buffer (result register
// plus skid) keeps input ready high while one result waits. Reset clears
// counter, compares, pointers and level, loads the period with its default;
// the sample store is not cleared.

module pwm_sample_ring_player #(
  parameter int unsigned BUFFERS            = psrp_pkg::BuffersDefault,
  parameter int unsigned SAMPLES_PER_BUFFER = psrp_pkg::SamplesPerBufferDefault,
  parameter int unsigned DUTY_WIDTH         = psrp_pkg::DutyWidthDefault,
  localparam int unsigned BufW  = (BUFFERS > 1) ? $clog2(BUFFERS) : 1,
  localparam int unsigned IdxW  = (SAMPLES_PER_BUFFER > 1) ? $clog2(SAMPLES_PER_BUFFER) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       cfg_we_i,
  input  logic [psrp_pkg::PeriodW-1:0] cfg_wdata_i,
  // input channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       op_i,
  input  logic [BufW-1:0]            write_buffer_i,
  input  logic [IdxW-1:0]            write_index_i,
  input  logic [DUTY_WIDTH-1:0]      write_value_i,
  // output channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       pwm_level_o,
  output logic                       period_start_o,
  output logic [DUTY_WIDTH-1:0]      active_duty_o,
  output logic                       refill_needed_o,
  output logic [BufW-1:0]            refill_buffer_o,
  output logic [BufW-1:0]            playing_buffer_o
);

  localparam int unsigned PeriodW = psrp_pkg::PeriodW;
  localparam int unsigned Depth   = BUFFERS * SAMPLES_PER_BUFFER;
  localparam int unsigned AddrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CmpW    = (PeriodW > DUTY_WIDTH) ? PeriodW : DUTY_WIDTH;

  typedef struct packed {
    logic                  pwm_level;
    logic                  period_start;
    logic [DUTY_WIDTH-1:0] active_duty;
    logic                  refill_needed;
    logic [BufW-1:0]       refill_buffer;
    logic [BufW-1:0]       playing_buffer;
  } result_t;

  // State
  logic [PeriodW-1:0]    period_q;
  logic [PeriodW-1:0]    count_q, count_d;
  logic [DUTY_WIDTH-1:0] active_q, active_d;
  logic                  shadow_zero_q;
  logic [BufW-1:0]       read_buffer_q, read_buffer_d;
  logic [IdxW-1:0]       read_sample_q, read_sample_d;
  logic [AddrW-1:0]      read_addr_q, read_addr_d;
  logic [BufW-1:0]       last_buffer_q, last_buffer_d;
  logic                  level_q, level_d;

  // Output buffering
  result_t main_q, skid_q, res_d;
  logic    main_valid_q, skid_valid_q;

  logic                  accept;
  logic                  is_tick;
  logic                  fetch;
  logic                  wr_en;
  logic [AddrW-1:0]      wr_addr;
  logic [DUTY_WIDTH-1:0] mem_rdata;
  logic [DUTY_WIDTH-1:0] shadow;
  logic [PeriodW:0]      count_inc;

  assign in_ready_o = ~skid_valid_q;
  assign accept     = in_valid_i & in_ready_o;
  assign is_tick    = (psrp_pkg::op_e'(op_i) == psrp_pkg::OpTick);
  assign fetch      = accept & is_tick & (count_q == '0);

  // Sample writes, out-of-range positions dropped
  assign wr_en = accept & ~is_tick
               & ({1'b0, write_buffer_i} < (BufW+1)'(BUFFERS))
               & ({1'b0, write_index_i} < (IdxW+1)'(SAMPLES_PER_BUFFER));
  assign wr_addr = AddrW'(AddrW'(write_buffer_i) * AddrW'(SAMPLES_PER_BUFFER))
                 + AddrW'(write_index_i);

  psrp_sample_mem #(
    .Depth (Depth),
    .Width (DUTY_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (write_value_i),
    .re_i    (fetch),
    .raddr_i (read_addr_q),
    .rdata_o (mem_rdata)
  );

  // Shadow compare is the last fetched sample (zero before the first fetch)
  assign shadow    = shadow_zero_q ? '0 : mem_rdata;
  assign count_inc = {1'b0, count_q} + (PeriodW+1)'(1);

  // Tick processing
  always_comb begin
    count_d       = count_q;
    active_d      = active_q;
    read_buffer_d = read_buffer_q;
    read_sample_d = read_sample_q;
    read_addr_d   = read_addr_q;
    last_buffer_d = last_buffer_q;
    level_d       = level_q;
    if (accept && is_tick) begin
      if (fetch) begin
        active_d      = shadow;
        last_buffer_d = read_buffer_q;
        if (read_sample_q == IdxW'(SAMPLES_PER_BUFFER - 1)) begin
          read_sample_d = '0;
          read_buffer_d = (read_buffer_q == BufW'(BUFFERS - 1)) ? '0
                        : read_buffer_q + BufW'(1);
        end else begin
          read_sample_d = read_sample_q + IdxW'(1);
        end
        read_addr_d = (read_addr_q == AddrW'(Depth - 1)) ? '0 : read_addr_q + AddrW'(1);
      end
      level_d = (CmpW'(count_q) < CmpW'(active_d));
      count_d = (count_inc >= {1'b0, period_q}) ? '0 : count_inc[PeriodW-1:0];
    end
  end

  // Result of the current beat
  always_comb begin
    res_d.pwm_level      = level_d;
    res_d.period_start   = fetch;
    res_d.active_duty    = active_d;
    res_d.refill_needed  = (read_buffer_d != last_buffer_d);
    res_d.refill_buffer  = last_buffer_d;
    res_d.playing_buffer = read_buffer_d;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q      <= psrp_pkg::PeriodReset;
      count_q       <= '0;
      active_q      <= '0;
      shadow_zero_q <= 1'b1;
      read_buffer_q <= '0;
      read_sample_q <= '0;
      read_addr_q   <= '0;
      last_buffer_q <= '0;
      level_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
      count_q       <= count_d;
      active_q      <= active_d;
      read_buffer_q <= read_buffer_d;
      read_sample_q <= read_sample_d;
      read_addr_q   <= read_addr_d;
      last_buffer_q <= last_buffer_d;
      level_q       <= level_d;
      if (fetch) begin
        shadow_zero_q <= 1'b0;
      end
    end
  end

  // Output register plus skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!main_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        main_valid_q <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!main_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        main_q <= skid_q;
      end else if (accept) begin
        main_q <= res_d;
      end
    end else if (accept) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o      = main_valid_q;
  assign pwm_level_o      = main_q.pwm_level;
  assign period_start_o   = main_q.period_start;
  assign active_duty_o    = main_q.active_duty;
  assign refill_needed_o  = main_q.refill_needed;
  assign refill_buffer_o  = main_q.refill_buffer;
  assign playing_buffer_o = main_q.playing_buffer;

  // Checks
  a_skid_needs_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid entry holds a beat while result register is empty");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && main_valid_q && !out_ready_i) |=> skid_valid_q)
    else $error("beat accepted during stall was not parked in skid entry");

  a_fetch_moves_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fetch |=> (last_buffer_q == $past(read_buffer_q)))
    else $error("refill buffer does not track the buffer just read");

  a_pointer_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, read_sample_q} < (IdxW+1)'(SAMPLES_PER_BUFFER))
    && ({1'b0, read_buffer_q} < (BufW+1)'(BUFFERS)))
    else $error("playback pointer left the sample ring");

endmodule
